FILE: src/smr_pkg.sv
// Shared types, constants and helper functions of the stepper move ramp block.
package smr_pkg;

  localparam int DELAY_W = 8;
  localparam int POS_W = 8;
  localparam int STEPS_W = 9;
  localparam int COIL_W = 6;
  localparam int PHASE_W = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam int STEPS_PER_REV_DEF = 200;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 8'd15;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 8'd7;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_DELAY = 1'b0,
    REG_MIN_DELAY = 1'b1
  } reg_index_t;

  // Input kinds.
  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef logic [COIL_W-1:0] coil_t;

  // Full-step coil sequence, lines EN0,L1,L2,EN1,L3,L4.
  function automatic coil_t coil_of(input logic [PHASE_W-1:0] ph);
    coil_t c;
    c = 6'h36;
    case (ph)
      2'd0: c = 6'h36;
      2'd1: c = 6'h2E;
      2'd2: c = 6'h2D;
      2'd3: c = 6'h35;
      default: c = 6'h36;
    endcase
    return c;
  endfunction

  // Next step interval: ramp down toward the minimum, then back up toward the
  // top once the remaining steps fit inside the deceleration span.
  function automatic logic [DELAY_W-1:0] ramp_next(
    input logic [DELAY_W-1:0] cur,
    input logic [DELAY_W-1:0] emin,
    input logic [DELAY_W-1:0] espan,
    input logic [DELAY_W-1:0] total,
    input logic [DELAY_W-1:0] idx
  );
    logic [DELAY_W:0]   top;
    logic [DELAY_W-1:0] remaining;
    logic [DELAY_W-1:0] res;
    top = {1'b0, emin} + {1'b0, espan};
    remaining = total - idx;
    if ({1'b0, remaining} > ({1'b0, espan} + 9'd1)) begin
      if (cur > emin) res = cur - 8'd1;
      else res = emin;
    end else begin
      if ({1'b0, cur} < top) res = cur + 8'd1;
      else res = top[DELAY_W-1:0];
    end
    return res;
  endfunction

  // Position update by a step count already reduced modulo one revolution.
  function automatic logic [POS_W-1:0] wrap_pos(
    input logic [POS_W-1:0] pos,
    input logic [POS_W-1:0] delta_mod,
    input logic             neg,
    input logic [POS_W-1:0] rev
  );
    logic [POS_W:0]   sum;
    logic [POS_W-1:0] res;
    if (!neg) begin
      sum = {1'b0, pos} + {1'b0, delta_mod};
      if (sum >= {1'b0, rev}) sum = sum - {1'b0, rev};
      res = sum[POS_W-1:0];
    end else begin
      if (pos >= delta_mod) begin
        res = pos - delta_mod;
      end else begin
        sum = {1'b0, pos} + {1'b0, rev} - {1'b0, delta_mod};
        res = sum[POS_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

FILE: src/smr_if.sv
// Channel interfaces of the stepper move ramp block: input items, results, configuration.
interface smr_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [smr_pkg::STEPS_W-1:0] steps;

  modport source (output valid, output kind, output steps, input ready);
  modport sink (input valid, input kind, input steps, output ready);
endinterface

interface smr_out_if;
  logic                           valid;
  logic                           ready;
  logic [smr_pkg::COIL_W-1:0]     coil_pattern;
  logic [smr_pkg::PHASE_W-1:0]    phase;
  logic [smr_pkg::POS_W-1:0]      position;
  logic                           busy_res;
  logic                           step_pulse;
  logic                           rejected;

  modport source (output valid, output coil_pattern, output phase, output position,
                  output busy_res, output step_pulse, output rejected, input ready);
  modport sink (input valid, input coil_pattern, input phase, input position,
                input busy_res, input step_pulse, input rejected, output ready);
endinterface

interface smr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [smr_pkg::CFG_INDEX_W-1:0]  index;
  logic [smr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/stepper_move_ramp_top.sv
// Top level of the stepper move ramp block: a full-step move generator with a linear delay ramp.
//
// This block drives a four-phase stepper in full steps. A move item (kind 0) carries a signed
// step count; the first coil pattern of the move is driven on the move item itself, and each
// later step waits for a number of tick items (kind 1) given by a linear ramp that starts at
// max_delay, falls by one per step to the effective minimum and climbs back near the end of the
// move. On short moves the minimum is raised so that the ramp stays symmetric. When the last
// step is driven, the shaft position advances by the step count, wrapped into one revolution.
// A move that arrives while a move is in progress is answered with rejected set and changes
// nothing. Every input item produces exactly one result item. The block takes one item per
// clock cycle: all of the work for an item is a compare, an increment and a small add between
// the state registers and the result register, so the rate is bounded only by the result
// register, which accepts a new item whenever it is empty or its result is taken in the same
// cycle. Configuration writes take effect with the next move.
module stepper_move_ramp_top #(
  parameter int STEPS_PER_REV = smr_pkg::STEPS_PER_REV_DEF
) (
  input  logic clk,
  input  logic rst,
  smr_in_if.sink    cmd,
  smr_out_if.source res,
  smr_cfg_if.sink   cfg
);

  localparam int DW = smr_pkg::DELAY_W;
  localparam int PW = smr_pkg::POS_W;
  localparam logic [PW-1:0] REV = PW'(STEPS_PER_REV);

  // Configuration registers.
  logic [DW-1:0] max_delay;
  logic [DW-1:0] min_delay;

  // Move state.
  logic [smr_pkg::PHASE_W-1:0] phase_index, phase_index_next;
  logic [PW-1:0] shaft_position, shaft_position_next;
  logic          moving, moving_next;
  logic          dir_neg, dir_neg_next;
  logic [DW-1:0] total_steps, total_steps_next;
  logic [DW-1:0] step_index, step_index_next;
  logic [DW-1:0] tick_count, tick_count_next;
  logic [DW-1:0] current_delay, current_delay_next;
  logic [DW-1:0] effective_min, effective_min_next;
  logic [DW-1:0] effective_span, effective_span_next;
  // Step count magnitude reduced modulo one revolution, kept until the move ends.
  logic [PW-1:0] pending_mod, pending_mod_next;

  // Result register.
  logic                        out_valid;
  logic [smr_pkg::COIL_W-1:0]  out_coil;
  logic [smr_pkg::PHASE_W-1:0] out_phase;
  logic [PW-1:0]               out_position;
  logic                        out_busy;
  logic                        out_pulse, pulse_next;
  logic                        out_rejected, rejected_next;

  logic accept;

  // Table of magnitude modulo one revolution, built at elaboration.
  logic [PW-1:0] mod_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_mod_tab
    localparam int ModVal = i % STEPS_PER_REV;
    assign mod_tab[i] = PW'(ModVal);
  end

  // The result register frees up when empty or when its result is taken now, so a new
  // item can be transferred in every cycle while the sink keeps up.
  assign cmd.ready = !out_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay <= smr_pkg::MAX_DELAY_RST;
      min_delay <= smr_pkg::MIN_DELAY_RST;
    end else if (cfg.valid) begin
      unique case (smr_pkg::reg_index_t'(cfg.index))
        smr_pkg::REG_MAX_DELAY: max_delay <= cfg.data;
        smr_pkg::REG_MIN_DELAY: min_delay <= cfg.data;
        default: ;
      endcase
    end
  end

  // Next-state logic for one item.
  always_comb begin
    logic          neg;
    logic [DW-1:0] mag;
    logic [DW-1:0] mn;
    logic [DW-1:0] span0;
    logic [DW-1:0] tick_inc;
    logic [smr_pkg::PHASE_W-1:0] phase_step;

    phase_index_next    = phase_index;
    shaft_position_next = shaft_position;
    moving_next         = moving;
    dir_neg_next        = dir_neg;
    total_steps_next    = total_steps;
    step_index_next     = step_index;
    tick_count_next     = tick_count;
    current_delay_next  = current_delay;
    effective_min_next  = effective_min;
    effective_span_next = effective_span;
    pending_mod_next    = pending_mod;
    pulse_next          = 1'b0;
    rejected_next       = 1'b0;

    // Magnitude of the requested step count; the most negative code saturates to 255.
    neg = cmd.steps[smr_pkg::STEPS_W-1];
    if (cmd.steps == 9'sh100) mag = 8'd255;
    else if (neg) mag = ~cmd.steps[DW-1:0] + 8'd1;
    else mag = cmd.steps[DW-1:0];

    // Effective minimum: clamp to max_delay, then raise it on short moves.
    mn = (min_delay > max_delay) ? max_delay : min_delay;
    span0 = max_delay - mn;
    if ({1'b0, mag} < {span0, 1'b0}) mn = max_delay - (mag >> 1);

    tick_inc = tick_count + 8'd1;
    phase_step = dir_neg ? phase_index - 2'd1 : phase_index + 2'd1;

    if (cmd.kind == smr_pkg::KIND_MOVE) begin
      if (moving) begin
        rejected_next = 1'b1;
      end else if (cmd.steps != '0) begin
        effective_min_next  = mn;
        effective_span_next = max_delay - mn;
        dir_neg_next        = neg;
        total_steps_next    = mag;
        pending_mod_next    = mod_tab[mag];
        phase_index_next    = neg ? phase_index - 2'd1 : phase_index + 2'd1;
        pulse_next          = 1'b1;
        if (mag <= 8'd1) begin
          // A one-step move completes on the move item itself.
          shaft_position_next = smr_pkg::wrap_pos(shaft_position, mod_tab[mag], neg, REV);
        end else begin
          moving_next        = 1'b1;
          step_index_next    = 8'd2;
          tick_count_next    = '0;
          current_delay_next = smr_pkg::ramp_next(max_delay, mn, max_delay - mn, mag, 8'd2);
        end
      end
    end else if (moving) begin
      tick_count_next = tick_inc;
      if (tick_inc >= current_delay) begin
        tick_count_next  = '0;
        phase_index_next = phase_step;
        pulse_next       = 1'b1;
        if (step_index >= total_steps) begin
          shaft_position_next = smr_pkg::wrap_pos(shaft_position, pending_mod, dir_neg, REV);
          moving_next         = 1'b0;
        end else begin
          step_index_next    = step_index + 8'd1;
          current_delay_next = smr_pkg::ramp_next(current_delay, effective_min,
                                                  effective_span, total_steps,
                                                  step_index + 8'd1);
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index    <= '0;
      shaft_position <= '0;
      moving         <= 1'b0;
      dir_neg        <= 1'b0;
      total_steps    <= '0;
      step_index     <= '0;
      tick_count     <= '0;
      current_delay  <= '0;
      effective_min  <= '0;
      effective_span <= '0;
      pending_mod    <= '0;
    end else if (accept) begin
      phase_index    <= phase_index_next;
      shaft_position <= shaft_position_next;
      moving         <= moving_next;
      dir_neg        <= dir_neg_next;
      total_steps    <= total_steps_next;
      step_index     <= step_index_next;
      tick_count     <= tick_count_next;
      current_delay  <= current_delay_next;
      effective_min  <= effective_min_next;
      effective_span <= effective_span_next;
      pending_mod    <= pending_mod_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload captures the state as it stands after the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_coil     <= smr_pkg::coil_of(phase_index_next);
      out_phase    <= phase_index_next;
      out_position <= shaft_position_next;
      out_busy     <= moving_next;
      out_pulse    <= pulse_next;
      out_rejected <= rejected_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.coil_pattern = out_coil;
  assign res.phase        = out_phase;
  assign res.position     = out_position;
  assign res.busy_res     = out_busy;
  assign res.step_pulse   = out_pulse;
  assign res.rejected     = out_rejected;

endmodule
